// ===== src/pek_pkg.sv =====
package pek_pkg;

   localparam int unsigned DATA_W = 32;

   typedef enum logic [1:0] {
      ACT_PUSH  = 2'd0,
      ACT_APPLY = 2'd1,
      ACT_END   = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_POW  = 3'd4,
      OP_RSV5 = 3'd5,
      OP_RSV6 = 3'd6,
      OP_RSV7 = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FEW      = 3'd1,
      ST_DIVZERO  = 3'd2,
      ST_BADEND   = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_FETCH = 6'b000010,
      S_MUL   = 6'b000100,
      S_DIV   = 6'b001000,
      S_PLOAD = 6'b010000,
      S_PMUL  = 6'b100000
   } state_type;

endpackage

// ===== src/postfix_stack_evaluator.sv =====
// postfix integer evaluator. issue one token transaction per start pulse while busy is low;
// push and end finish in the idle state, add and subtract pass through the fetch state, any
// other operator goes through fetch and then its arithmetic: multiply and divide run on a
// bit-serial shift-add / restoring-divide unit, power runs one pass (a load step and a serial
// multiply, acc*sq and sq*sq together) per exponent bit up to the highest set bit. the top
// of stack lives in a register, the rest in a small one-read one-write array. results (ok or
// error) appear for exactly one cycle with rsp_strobe and must be captured then; the receiver
// cannot stall the block. every result clears the stack.
module postfix_stack_evaluator #(
   parameter int STACK_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic signed [31:0] req_operand_value,
   input  logic [2:0]  req_operator_code,
   output logic        rsp_strobe,
   output logic signed [31:0] rsp_value,
   output logic [2:0]  rsp_status
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int DW     = pek_pkg::DATA_W;

   // control state
   pek_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [4:0]         step_ff, step_in;
   logic               strobe_ff, strobe_in;

   // payload
   logic [DW-1:0] tos_ff, tos_in;
   logic [DW-1:0] rdata_ff;
   logic [2:0]    op_ff, op_in;
   logic [DW-1:0] mcand_ff, mcand_in;     // shared multiplicand, shifts left
   logic [DW-1:0] mpl1_ff, mpl1_in;       // multiplier bits, shift right
   logic [DW-1:0] mpl2_ff, mpl2_in;
   logic [DW-1:0] prod1_ff, prod1_in;
   logic [DW-1:0] prod2_ff, prod2_in;
   logic [DW-1:0] acc_ff, acc_in;
   logic [DW-1:0] sq_ff, sq_in;
   logic [DW-1:0] exp_ff, exp_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic          neg_ff, neg_in;
   logic [DW-1:0] value_ff, value_in;
   logic [2:0]    status_ff, status_in;

   // stack body below the top
   logic [DW-1:0]     stack_mem [STACK_DEPTH];
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [CNT_W-1:0]  cnt_m1, cnt_m2;

   // serial datapath
   logic [DW-1:0] p1_step, p2_step, a_mag, b_mag, sum, diff;
   logic [DW:0]   trial;
   logic          fit;

   assign cnt_m1  = count_ff - CNT_W'(1);
   assign cnt_m2  = count_ff - CNT_W'(2);
   assign wr_addr = cnt_m1[ADDR_W-1:0];
   assign rd_addr = cnt_m2[ADDR_W-1:0];

   assign p1_step = mpl1_ff[0] ? prod1_ff + mcand_ff : prod1_ff;
   assign p2_step = mpl2_ff[0] ? prod2_ff + mcand_ff : prod2_ff;
   assign a_mag   = rdata_ff[DW-1] ? -rdata_ff : rdata_ff;
   assign b_mag   = tos_ff[DW-1] ? -tos_ff : tos_ff;
   assign sum     = rdata_ff + tos_ff;
   assign diff    = rdata_ff - tos_ff;
   assign trial   = {rem_ff, quo_ff[DW-1]};
   assign fit     = trial >= {1'b0, dvs_ff};

   assign busy       = (state_ff != pek_pkg::S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_value  = value_ff;
   assign rsp_status = status_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      step_in   = step_ff;
      strobe_in = 1'b0;
      tos_in    = tos_ff;
      op_in     = op_ff;
      mcand_in  = mcand_ff;
      mpl1_in   = mpl1_ff;
      mpl2_in   = mpl2_ff;
      prod1_in  = prod1_ff;
      prod2_in  = prod2_ff;
      acc_in    = acc_ff;
      sq_in     = sq_ff;
      exp_in    = exp_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      neg_in    = neg_ff;
      value_in  = value_ff;
      status_in = status_ff;
      wr_en     = 1'b0;

      unique case (state_ff)
         pek_pkg::S_IDLE: begin
            if (start) begin
               unique case (pek_pkg::action_type'(req_action))
                  pek_pkg::ACT_PUSH: begin
                     if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                        strobe_in = 1'b1;
                        value_in  = '0;
                        status_in = pek_pkg::ST_OVERFLOW;
                        count_in  = '0;
                     end else begin
                        // spill old top into the array
                        wr_en    = (count_ff != '0);
                        tos_in   = req_operand_value;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  pek_pkg::ACT_APPLY: begin
                     if (req_operator_code <= pek_pkg::OP_POW) begin
                        if (count_ff < CNT_W'(2)) begin
                           strobe_in = 1'b1;
                           value_in  = '0;
                           status_in = pek_pkg::ST_FEW;
                           count_in  = '0;
                        end else begin
                           op_in    = req_operator_code;
                           state_in = pek_pkg::S_FETCH;
                        end
                     end
                  end
                  pek_pkg::ACT_END: begin
                     strobe_in = 1'b1;
                     count_in  = '0;
                     if (count_ff == CNT_W'(1)) begin
                        value_in  = tos_ff;
                        status_in = pek_pkg::ST_OK;
                     end else begin
                        value_in  = '0;
                        status_in = pek_pkg::ST_BADEND;
                     end
                  end
                  default: ;
               endcase
            end
         end

         pek_pkg::S_FETCH: begin
            // left operand now in rdata_ff, right operand is the top register
            step_in  = '0;
            state_in = pek_pkg::S_IDLE;
            unique case (pek_pkg::op_type'(op_ff))
               pek_pkg::OP_ADD: begin
                  tos_in   = sum;
                  count_in = cnt_m1;
               end
               pek_pkg::OP_SUB: begin
                  tos_in   = diff;
                  count_in = cnt_m1;
               end
               pek_pkg::OP_MUL: begin
                  mcand_in = rdata_ff;
                  mpl1_in  = tos_ff;
                  prod1_in = '0;
                  state_in = pek_pkg::S_MUL;
               end
               pek_pkg::OP_DIV: begin
                  if (tos_ff == '0) begin
                     strobe_in = 1'b1;
                     value_in  = '0;
                     status_in = pek_pkg::ST_DIVZERO;
                     count_in  = '0;
                  end else begin
                     rem_in   = '0;
                     quo_in   = a_mag;
                     dvs_in   = b_mag;
                     neg_in   = rdata_ff[DW-1] ^ tos_ff[DW-1];
                     state_in = pek_pkg::S_DIV;
                  end
               end
               default: begin
                  if (tos_ff[DW-1]) begin
                     // negative exponent
                     if (rdata_ff == '0) begin
                        strobe_in = 1'b1;
                        value_in  = '0;
                        status_in = pek_pkg::ST_DIVZERO;
                        count_in  = '0;
                     end else begin
                        count_in = cnt_m1;
                        if (rdata_ff == DW'(1))
                           tos_in = DW'(1);
                        else if (rdata_ff == '1)
                           tos_in = tos_ff[0] ? '1 : DW'(1);
                        else
                           tos_in = '0;
                     end
                  end else if (tos_ff == '0) begin
                     tos_in   = DW'(1);
                     count_in = cnt_m1;
                  end else begin
                     acc_in   = DW'(1);
                     sq_in    = rdata_ff;
                     exp_in   = tos_ff;
                     state_in = pek_pkg::S_PLOAD;
                  end
               end
            endcase
         end

         pek_pkg::S_MUL: begin
            prod1_in = p1_step;
            mcand_in = mcand_ff << 1;
            mpl1_in  = mpl1_ff >> 1;
            step_in  = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               tos_in   = p1_step;
               count_in = cnt_m1;
               state_in = pek_pkg::S_IDLE;
            end
         end

         pek_pkg::S_DIV: begin
            // restoring division, one quotient bit a cycle
            rem_in  = fit ? DW'(trial - {1'b0, dvs_ff}) : trial[DW-1:0];
            quo_in  = {quo_ff[DW-2:0], fit};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               tos_in   = neg_ff ? -{quo_ff[DW-2:0], fit} : {quo_ff[DW-2:0], fit};
               count_in = cnt_m1;
               state_in = pek_pkg::S_IDLE;
            end
         end

         pek_pkg::S_PLOAD: begin
            mcand_in = sq_ff;
            mpl1_in  = acc_ff;
            mpl2_in  = sq_ff;
            prod1_in = '0;
            prod2_in = '0;
            step_in  = '0;
            state_in = pek_pkg::S_PMUL;
         end

         pek_pkg::S_PMUL: begin
            // acc*sq and sq*sq share the shifting multiplicand
            prod1_in = p1_step;
            prod2_in = p2_step;
            mcand_in = mcand_ff << 1;
            mpl1_in  = mpl1_ff >> 1;
            mpl2_in  = mpl2_ff >> 1;
            step_in  = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               acc_in = exp_ff[0] ? p1_step : acc_ff;
               sq_in  = p2_step;
               exp_in = exp_ff >> 1;
               if ((exp_ff >> 1) == '0) begin
                  tos_in   = exp_ff[0] ? p1_step : acc_ff;
                  count_in = cnt_m1;
                  state_in = pek_pkg::S_IDLE;
               end else begin
                  state_in = pek_pkg::S_PLOAD;
               end
            end
         end

         default: state_in = pek_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pek_pkg::S_IDLE;
         count_ff  <= '0;
         step_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         step_ff   <= step_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff    <= tos_in;
      op_ff     <= op_in;
      mcand_ff  <= mcand_in;
      mpl1_ff   <= mpl1_in;
      mpl2_ff   <= mpl2_in;
      prod1_ff  <= prod1_in;
      prod2_ff  <= prod2_in;
      acc_ff    <= acc_in;
      sq_ff     <= sq_in;
      exp_ff    <= exp_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dvs_ff    <= dvs_in;
      neg_ff    <= neg_in;
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   // stack array: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en)
         stack_mem[wr_addr] <= tos_ff;
      rdata_ff <= stack_mem[rd_addr];
   end

`ifndef SYNTHESIS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != pek_pkg::ST_OK |-> rsp_value == '0)
      else $error("error result with nonzero value");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> count_ff == '0)
      else $error("stack not cleared after result");

   a_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_push: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_action == pek_pkg::ACT_PUSH
      && count_ff < CNT_W'(STACK_DEPTH)
      |=> count_ff == $past(count_ff) + CNT_W'(1) && !rsp_strobe)
      else $error("push did not grow the stack");
`endif

endmodule

// ===== dv/tb_postfix_stack_evaluator.sv =====
module tb_postfix_stack_evaluator;

   // slowest transaction: a power with a high exponent
   localparam int SLOWEST_OP   = 1100;
   localparam int CYCLE_LIMIT  = 10000 * SLOWEST_OP;
   localparam int DRAIN_CYCLES = 1200;
   localparam int DEPTH        = 16;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_action = pek_pkg::ACT_NONE;
   logic signed [31:0] req_operand_value = '0;
   logic [2:0]        req_operator_code = pek_pkg::OP_ADD;
   logic              rsp_strobe;
   logic signed [31:0] rsp_value;
   logic [2:0]        rsp_status;

   postfix_stack_evaluator #(.STACK_DEPTH(DEPTH)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_operand_value(req_operand_value),
      .req_operator_code(req_operator_code), .rsp_strobe(rsp_strobe),
      .rsp_value(rsp_value), .rsp_status(rsp_status)
   );

   always #2 clock = ~clock;

   // predicted evaluator state
   logic [31:0] model_stack [DEPTH];
   int          model_depth;

   typedef struct packed {
      logic [31:0]         value;
      pek_pkg::status_type status;
   } outcome_type;

   outcome_type pending_outcomes [$];
   int          mismatch_count;
   int          cycle_count;
   int          send_idle_pct;

   // ---------------------------------------------------------------- prediction

   function automatic logic [31:0] magnitude(logic [31:0] x);
      return x[31] ? -x : x;
   endfunction

   // truncating signed divide on raw words; most negative / -1 wraps
   function automatic logic [31:0] trunc_divide(logic [31:0] a, logic [31:0] b);
      logic [31:0] q;
      q = magnitude(a) / magnitude(b);
      return (a[31] != b[31]) ? -q : q;
   endfunction

   // wrapped square-and-multiply over the low 31 exponent bits
   function automatic logic [31:0] wrapped_power(logic [31:0] base, logic [31:0] ex);
      logic [31:0] acc;
      logic [31:0] sq;
      acc = 32'd1;
      sq  = base;
      for (int i = 0; i < 31; i++) begin
         if (ex[i]) acc = acc * sq;
         sq = sq * sq;
      end
      return acc;
   endfunction

   function automatic void post_outcome(logic [31:0] v, pek_pkg::status_type s);
      outcome_type o;
      o.value  = (s == pek_pkg::ST_OK) ? v : 32'd0;
      o.status = s;
      pending_outcomes.push_back(o);
      model_depth = 0;
   endfunction

   function automatic void predict_token(logic [1:0] act, logic [31:0] opnd, logic [2:0] code);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] r;
      case (act)
         pek_pkg::ACT_PUSH: begin
            if (model_depth >= DEPTH) post_outcome(0, pek_pkg::ST_OVERFLOW);
            else begin
               model_stack[model_depth] = opnd;
               model_depth++;
            end
         end
         pek_pkg::ACT_APPLY: begin
            if (code > pek_pkg::OP_POW) return;
            if (model_depth < 2) begin
               post_outcome(0, pek_pkg::ST_FEW);
               return;
            end
            b = model_stack[model_depth-1];
            a = model_stack[model_depth-2];
            case (code)
               pek_pkg::OP_ADD: r = a + b;
               pek_pkg::OP_SUB: r = a - b;
               pek_pkg::OP_MUL: r = a * b;
               pek_pkg::OP_DIV: begin
                  if (b == 0) begin
                     post_outcome(0, pek_pkg::ST_DIVZERO);
                     return;
                  end
                  r = trunc_divide(a, b);
               end
               default: begin
                  if (b[31]) begin
                     // negative exponent
                     if (a == 0) begin
                        post_outcome(0, pek_pkg::ST_DIVZERO);
                        return;
                     end
                     if (a == 32'd1) r = 32'd1;
                     else if (a == 32'hFFFF_FFFF) r = b[0] ? 32'hFFFF_FFFF : 32'd1;
                     else r = 32'd0;
                  end else r = wrapped_power(a, b);
               end
            endcase
            model_depth--;
            model_stack[model_depth-1] = r;
         end
         pek_pkg::ACT_END: begin
            if (model_depth == 1) post_outcome(model_stack[0], pek_pkg::ST_OK);
            else post_outcome(0, pek_pkg::ST_BADEND);
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- driving

   // start stays high after an accepted transaction until the next one or an idle cycle
   task automatic send_token(logic [1:0] act, logic [31:0] opnd, logic [2:0] code);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start             <= 1'b1;
      req_action        <= act;
      req_operand_value <= opnd;
      req_operator_code <= code;
      @(posedge clock);
      while (busy) @(posedge clock);
      // accepted at this edge
      predict_token(act, opnd, code);
   endtask

   task automatic push(logic [31:0] v);
      send_token(pek_pkg::ACT_PUSH, v, $urandom_range(7));
   endtask

   task automatic apply(pek_pkg::op_type op);
      send_token(pek_pkg::ACT_APPLY, $urandom, op);
   endtask

   task automatic finish_expr();
      send_token(pek_pkg::ACT_END, $urandom, $urandom_range(7));
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      outcome_type exp_o;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_strobe) begin
         if (pending_outcomes.size() == 0)
            report_mismatch($sformatf("unexpected result %0d status %0d", rsp_value, rsp_status));
         else begin
            exp_o = pending_outcomes.pop_front();
            if (rsp_value !== exp_o.value)
               report_mismatch($sformatf("value %h, expected %h", rsp_value, exp_o.value));
            if (rsp_status !== exp_o.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, exp_o.status));
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   function automatic logic [31:0] random_operand();
      case ($urandom_range(5))
         0: return $urandom_range(3) - 1;
         1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         2: return $urandom_range(20) - 10;
         default: return $urandom;
      endcase
   endfunction

   // small exponents keep power transactions short
   function automatic logic [31:0] random_exponent();
      case ($urandom_range(9))
         0: return -($urandom_range(3) + 1);
         1: return $urandom;
         default: return $urandom_range(12);
      endcase
   endfunction

   task automatic test_arith_extremes();
      push(32'h7FFF_FFFF); push(32'd1); apply(pek_pkg::OP_ADD); finish_expr();
      push(32'h8000_0000); push(32'd1); apply(pek_pkg::OP_SUB); finish_expr();
      push(32'h8000_0000); push(32'hFFFF_FFFF); apply(pek_pkg::OP_MUL); finish_expr();
      push(-7); push(2); apply(pek_pkg::OP_DIV); finish_expr();
      push(32'h8000_0000); push(32'hFFFF_FFFF); apply(pek_pkg::OP_DIV); finish_expr();
   endtask

   task automatic test_error_cases();
      push(5); push(0); apply(pek_pkg::OP_DIV);         // divide by zero
      push(0); push(-3); apply(pek_pkg::OP_POW);        // zero to negative power
      push(4); apply(pek_pkg::OP_ADD);                  // too few operands
      finish_expr();                                    // end on empty stack
      push(1); push(2); finish_expr();                  // end with two values
      for (int i = 0; i <= DEPTH; i++) push($urandom);  // overflow on full stack
      apply(pek_pkg::OP_RSV5);                          // ignored tokens
      send_token(pek_pkg::ACT_NONE, 0, 0);
   endtask

   task automatic test_power_cases();
      push(0); push(0); apply(pek_pkg::OP_POW); finish_expr();
      push(1); push(-5); apply(pek_pkg::OP_POW); finish_expr();
      push(-1); push(-5); apply(pek_pkg::OP_POW); finish_expr();
      push(-1); push(-4); apply(pek_pkg::OP_POW); finish_expr();
      push(3); push(-1); apply(pek_pkg::OP_POW); finish_expr();
      push(3); push(32'h7FFF_FFFF); apply(pek_pkg::OP_POW); finish_expr();
   endtask

   // well-formed random expressions, with some broken ones and noise
   task automatic test_random_expressions(int n_tokens);
      int sent;
      int depth;
      int target;
      logic [31:0] exv;
      sent = 0;
      while (sent < n_tokens) begin
         if ($urandom_range(9) == 0) begin
            send_token($urandom_range(3), $urandom, $urandom_range(7));
            sent++;
         end else begin
            target = $urandom_range(1, $urandom_range(3) == 0 ? DEPTH : 5);
            depth = 0;
            while (depth < target || depth > 1) begin
               if (depth < 2 || (depth < target && $urandom_range(1))) begin
                  push(random_operand());
                  depth++;
               end else begin
                  if ($urandom_range(3) == 0) begin
                     exv = random_exponent();
                     // fold the top two by a subtract, then raise the result to a random exponent
                     apply(pek_pkg::OP_SUB);
                     push(exv);
                     apply(pek_pkg::OP_POW);
                     sent += 2;
                  end else apply(pek_pkg::op_type'($urandom_range(3)));
                  depth--;
               end
               sent++;
               if (model_depth != depth) break;   // an error cleared the stack
            end
            if ($urandom_range(9) == 0) push(random_operand());
            finish_expr();
            sent++;
         end
      end
   endtask

   initial begin
      mismatch_count = 0;
      cycle_count    = 0;
      model_depth    = 0;
      send_idle_pct  = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_arith_extremes();
      test_error_cases();
      test_power_cases();

      send_idle_pct = 35;
      test_random_expressions(625);
      send_idle_pct = 53;
      test_random_expressions(625);
      send_idle_pct = 0;
      test_random_expressions(625);
      start <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/pek_pkg.sv
src/postfix_stack_evaluator.sv
dv/tb_postfix_stack_evaluator.sv
